// ----- src/ssp_pkg.sv -----
// Shared types, codes and constants for the servo status packet parser.
package ssp_pkg;

  localparam int unsigned MAX_PARAMS = 64;
  localparam int unsigned CNT_W      = 7;

  localparam logic [7:0] HDR_BYTE   = 8'hFF;
  localparam logic [7:0] ANY_ID     = 8'hFE;
  localparam logic [7:0] LEN_EXTRA  = 8'd2;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] CFG_EXPECTED_ID  = 2'd0;
  localparam logic [1:0] CFG_PARAM_COUNT  = 2'd1;
  localparam logic [1:0] CFG_HEADER_LIMIT = 2'd2;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_WRONG_ID  = 3'd1,
    ST_WRONG_LEN = 3'd2,
    ST_BAD_CSUM  = 3'd3,
    ST_NO_HEADER = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_HDR   = 3'd1,
    PH_LEN   = 3'd2,
    PH_ERR   = 3'd3,
    PH_PARAM = 3'd4,
    PH_CSUM  = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0]       expected_id;
    logic [CNT_W-1:0] param_count;
    logic [7:0]       header_byte_limit;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [5:0] data_index;
    logic [2:0] status;
    logic [7:0] servo_error;
    logic [7:0] servo_id;
    logic       last;
  } result_t;

endpackage

// ----- src/ssp_in_if.sv -----
// Input byte channel: valid/ready with op and received byte.
interface ssp_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink (input valid, input op, input rx_byte, output ready);
endinterface

// ----- src/ssp_out_if.sv -----
// Result channel: valid/ready with parameter byte or packet status fields.
interface ssp_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic [5:0] data_index;
  logic [2:0] status;
  logic [7:0] servo_error;
  logic [7:0] servo_id;
  logic       last;

  modport source (output valid, output kind, output data_byte, output data_index,
                  output status, output servo_error, output servo_id, output last,
                  input ready);
  modport sink (input valid, input kind, input data_byte, input data_index,
                input status, input servo_error, input servo_id, input last,
                output ready);
endinterface

// ----- src/ssp_cfg_if.sv -----
// Configuration write channel: valid/ready with register index and data.
interface ssp_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/servo_status_packet_parser.sv -----
// Servo status packet parser: one received byte per clock, results through a
// two-entry output buffer. Each accepted byte is handled combinationally into a
// result register, and its result, if any, then passes to the output register
// or skid entry. Input ready drops while the skid entry holds a result, or while a
// fresh result meets a stalled output register; otherwise the block takes one
// byte per clock. Configuration writes are always ready and take effect on the
// next byte.
module servo_status_packet_parser import ssp_pkg::*; (
  input logic       clk,
  input logic       rst,
  ssp_in_if.sink    in_ch,
  ssp_out_if.source out_ch,
  ssp_cfg_if.sink   cfg
);

  cfg_t    cfg_q;
  logic    in_accept;
  logic    res_valid;
  result_t res;
  result_t out_res;
  logic    space;

  assign cfg.ready    = 1'b1;
  assign in_ch.ready  = space;
  assign in_accept    = in_ch.valid && space;

  ssp_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_q)
  );

  ssp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .op        (in_ch.op),
    .rx_byte   (in_ch.rx_byte),
    .cfg       (cfg_q),
    .res_valid (res_valid),
    .res       (res)
  );

  ssp_out_buf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .space     (space),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.kind        = out_res.kind;
  assign out_ch.data_byte   = out_res.data_byte;
  assign out_ch.data_index  = out_res.data_index;
  assign out_ch.status      = out_res.status;
  assign out_ch.servo_error = out_res.servo_error;
  assign out_ch.servo_id    = out_res.servo_id;
  assign out_ch.last        = out_res.last;

`ifndef ASSERT_OFF
  a_full_has_output: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> out_ch.valid)
    else $error("buffer full without a visible result");

  a_error_only_ok: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status != ST_OK) |-> (out_ch.servo_error == 8'd0))
    else $error("servo error reported on a failed packet");

  a_data_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.kind == KIND_DATA) |-> (!out_ch.last && out_ch.status == ST_OK))
    else $error("parameter byte marked as packet end");

  a_no_header_id: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status == ST_NO_HEADER) |-> (out_ch.servo_id == 8'd0))
    else $error("no-header status carries an id");
`endif

endmodule

// ----- src/ssp_cfg_regs.sv -----
// Configuration register file for the parser.
module ssp_cfg_regs import ssp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  logic [1:0] wr_index,
  input  logic [7:0] wr_data,
  output cfg_t       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_id       <= 8'd1;
      cfg.param_count       <= '0;
      cfg.header_byte_limit <= 8'd10;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_EXPECTED_ID:  cfg.expected_id       <= wr_data;
        CFG_PARAM_COUNT:  cfg.param_count       <= wr_data[CNT_W-1:0];
        CFG_HEADER_LIMIT: cfg.header_byte_limit <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- src/ssp_core.sv -----
// Per-byte packet state machine: header hunt, field checks, checksum.
module ssp_core import ssp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       op,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output logic       res_valid,
  output result_t    res
);

  phase_t           phase, phase_next;
  logic             prev_was_ff, prev_was_ff_next;
  logic [7:0]       skip_count, skip_count_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [CNT_W-1:0] param_counter, param_counter_next;
  logic [7:0]       seen_id, seen_id_next;
  logic [7:0]       seen_error, seen_error_next;

  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] cnt_inc;
  logic             emit;
  logic             restart;
  logic             res_valid_next;
  result_t          res_next;

  assign n_eff   = (cfg.param_count > CNT_W'(MAX_PARAMS)) ? CNT_W'(MAX_PARAMS)
                                                          : cfg.param_count;
  assign cnt_inc = param_counter + CNT_W'(1);

  always_comb begin
    phase_next         = phase;
    prev_was_ff_next   = prev_was_ff;
    skip_count_next    = skip_count;
    running_sum_next   = running_sum;
    param_counter_next = param_counter;
    seen_id_next       = seen_id;
    seen_error_next    = seen_error;
    emit               = 1'b0;
    restart            = 1'b0;
    res_next           = '0;

    if (op == OP_RESTART) begin
      restart = 1'b1;
    end else begin
      unique case (phase)
        PH_HDR: begin
          if (rx_byte != HDR_BYTE) begin
            seen_id_next     = rx_byte;
            running_sum_next = rx_byte;
            if (cfg.expected_id != ANY_ID && rx_byte != cfg.expected_id) begin
              emit             = 1'b1;
              res_next.status  = ST_WRONG_ID;
              res_next.servo_id = rx_byte;
            end else begin
              phase_next = PH_LEN;
            end
          end
        end
        PH_LEN: begin
          if (rx_byte != (8'(n_eff) + LEN_EXTRA)) begin
            emit              = 1'b1;
            res_next.status   = ST_WRONG_LEN;
            res_next.servo_id = seen_id;
          end else begin
            running_sum_next = running_sum + rx_byte;
            phase_next       = PH_ERR;
          end
        end
        PH_ERR: begin
          seen_error_next    = rx_byte;
          running_sum_next   = running_sum + rx_byte;
          param_counter_next = '0;
          phase_next         = (n_eff == '0) ? PH_CSUM : PH_PARAM;
        end
        PH_PARAM: begin
          res_next.kind       = KIND_DATA;
          res_next.data_byte  = rx_byte;
          res_next.data_index = param_counter[5:0];
          res_next.servo_id   = seen_id;
          running_sum_next    = running_sum + rx_byte;
          param_counter_next  = cnt_inc;
          if (cnt_inc >= n_eff) phase_next = PH_CSUM;
        end
        PH_CSUM: begin
          emit              = 1'b1;
          res_next.servo_id = seen_id;
          if (~running_sum != rx_byte) begin
            res_next.status = ST_BAD_CSUM;
          end else begin
            res_next.status      = ST_OK;
            res_next.servo_error = seen_error;
          end
        end
        default: begin
          if (rx_byte == HDR_BYTE && prev_was_ff) begin
            phase_next       = PH_HDR;
            prev_was_ff_next = 1'b0;
            skip_count_next  = '0;
          end else begin
            prev_was_ff_next = (rx_byte == HDR_BYTE);
            if (({1'b0, skip_count} + 9'd1) > {1'b0, cfg.header_byte_limit}) begin
              emit            = 1'b1;
              res_next.status = ST_NO_HEADER;
            end else begin
              skip_count_next = skip_count + 8'd1;
            end
          end
        end
      endcase
    end

    if (emit) begin
      res_next.kind = KIND_STATUS;
      res_next.last = 1'b1;
      restart       = 1'b1;
    end

    if (restart) begin
      phase_next         = PH_HUNT;
      prev_was_ff_next   = 1'b0;
      skip_count_next    = '0;
      running_sum_next   = '0;
      param_counter_next = '0;
    end

    res_valid_next = (op == OP_BYTE) && (emit || phase == PH_PARAM);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      prev_was_ff   <= 1'b0;
      skip_count    <= '0;
      running_sum   <= '0;
      param_counter <= '0;
      seen_id       <= '0;
      seen_error    <= '0;
      res_valid     <= 1'b0;
    end else begin
      res_valid <= accept && res_valid_next;
      if (accept) begin
        phase         <= phase_next;
        prev_was_ff   <= prev_was_ff_next;
        skip_count    <= skip_count_next;
        running_sum   <= running_sum_next;
        param_counter <= param_counter_next;
        seen_id       <= seen_id_next;
        seen_error    <= seen_error_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) res <= res_next;
  end

endmodule

// ----- src/ssp_out_buf.sv -----
// Two-entry result buffer: output register plus skid entry.
module ssp_out_buf import ssp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    res_valid,
  input  result_t res,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    skid_valid;
  result_t skid_res;
  logic    main_free;

  assign main_free = !out_valid || out_ready;
  // a result landing on a stalled output register takes the skid entry
  assign space     = !skid_valid && !(res_valid && !main_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      out_valid  <= skid_valid || res_valid;
      skid_valid <= skid_valid && res_valid;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      out_res <= skid_valid ? skid_res : res;
      if (skid_valid) skid_res <= res;
    end else if (res_valid) begin
      skid_res <= res;
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the servo status packet parser.
module testbench;
  import ssp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          PHASE_ITEMS = 140;
  localparam int          HOLD_CYCLES = 300;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } bus_item_t;

  logic clk = 1'b0;
  logic rst;

  ssp_in_if  in_ch();
  ssp_out_if out_ch();
  ssp_cfg_if cfg_ch();

  servo_status_packet_parser u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  bus_item_t   bus_bytes[$];
  result_t     expected_results[$];
  bus_item_t   next_item;
  result_t     got_result;
  result_t     want_result;
  int          queued = 0;
  int          errors = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  int unsigned recv_hold_left = 0;
  int unsigned cycle_count = 0;

  // parser state as the block should hold it
  logic [7:0] want_id = 8'd1;
  logic [6:0] want_params = 7'd0;
  logic [7:0] hunt_limit = 8'd10;
  phase_t     hunt_phase = PH_HUNT;
  logic       prev_ff = 1'b0;
  logic [7:0] skipped = 8'd0;
  logic [7:0] csum_acc = 8'd0;
  logic [6:0] param_idx = 7'd0;
  logic [7:0] seen_id_q = 8'd0;
  logic [7:0] seen_err_q = 8'd0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void restart_hunt();
    hunt_phase = PH_HUNT;
    prev_ff    = 1'b0;
    skipped    = 8'd0;
    csum_acc   = 8'd0;
    param_idx  = 7'd0;
  endfunction

  function automatic void post_status(status_t st, logic [7:0] err, logic [7:0] id);
    result_t r;
    r = '{kind: KIND_STATUS, data_byte: 8'd0, data_index: 6'd0, status: st,
          servo_error: err, servo_id: id, last: 1'b1};
    expected_results.push_back(r);
    restart_hunt();
  endfunction

  function automatic void predict_parser_byte(logic op, logic [7:0] b);
    logic [7:0] n;
    logic [7:0] want_csum;
    result_t    r;
    n = (want_params > MAX_PARAMS) ? 8'(MAX_PARAMS) : {1'b0, want_params};
    want_csum = ~csum_acc;
    if (op == OP_RESTART) begin
      restart_hunt();
      return;
    end
    case (hunt_phase)
      PH_HDR: begin
        if (b != HDR_BYTE) begin
          seen_id_q = b;
          csum_acc  = b;
          if (want_id != ANY_ID && b != want_id) post_status(ST_WRONG_ID, 8'd0, b);
          else hunt_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        if (b != 8'(n + LEN_EXTRA)) begin
          post_status(ST_WRONG_LEN, 8'd0, seen_id_q);
        end else begin
          csum_acc   = csum_acc + b;
          hunt_phase = PH_ERR;
        end
      end
      PH_ERR: begin
        seen_err_q = b;
        csum_acc   = csum_acc + b;
        param_idx  = 7'd0;
        hunt_phase = (n == 8'd0) ? PH_CSUM : PH_PARAM;
      end
      PH_PARAM: begin
        r = '{kind: KIND_DATA, data_byte: b, data_index: param_idx[5:0], status: ST_OK,
              servo_error: 8'd0, servo_id: seen_id_q, last: 1'b0};
        expected_results.push_back(r);
        csum_acc  = csum_acc + b;
        param_idx = param_idx + 7'd1;
        if ({1'b0, param_idx} >= n) hunt_phase = PH_CSUM;
      end
      PH_CSUM: begin
        if (want_csum != b) post_status(ST_BAD_CSUM, 8'd0, seen_id_q);
        else post_status(ST_OK, seen_err_q, seen_id_q);
      end
      default: begin
        if (b == HDR_BYTE && prev_ff) begin
          hunt_phase = PH_HDR;
          prev_ff    = 1'b0;
          skipped    = 8'd0;
        end else begin
          prev_ff = (b == HDR_BYTE);
          if ({1'b0, skipped} + 9'd1 > {1'b0, hunt_limit})
            post_status(ST_NO_HEADER, 8'd0, 8'd0);
          else skipped = skipped + 8'd1;
        end
      end
    endcase
  endfunction

  function automatic void report_mismatch(string tag, result_t want, result_t got);
    errors++;
    if (errors <= 10) begin
      $display("%s: exp kind=%0d byte=%02h idx=%0d st=%0d err=%02h id=%02h last=%0d",
               tag, want.kind, want.data_byte, want.data_index, want.status,
               want.servo_error, want.servo_id, want.last);
      $display("%s: got kind=%0d byte=%02h idx=%0d st=%0d err=%02h id=%02h last=%0d",
               tag, got.kind, got.data_byte, got.data_index, got.status,
               got.servo_error, got.servo_id, got.last);
    end
  endfunction

  // input driver; the predictor is updated on each accepted transfer
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_parser_byte(in_ch.op, in_ch.rx_byte);
      if (!in_ch.valid || in_ch.ready) begin
        if (bus_bytes.size() != 0 && $urandom_range(99) >= send_idle) begin
          next_item = bus_bytes.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.op      <= next_item.op;
          in_ch.rx_byte <= next_item.rx_byte;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got_result = '{out_ch.kind, out_ch.data_byte, out_ch.data_index, out_ch.status,
                       out_ch.servo_error, out_ch.servo_id, out_ch.last};
        if (expected_results.size() == 0) begin
          report_mismatch("no result expected", '0, got_result);
        end else begin
          want_result = expected_results.pop_front();
          if (got_result !== want_result) report_mismatch("mismatch", want_result, got_result);
        end
      end
      out_ch.ready <= (recv_hold_left == 0) && ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (recv_hold_left != 0) recv_hold_left <= recv_hold_left - 1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void queue_byte(logic op, logic [7:0] b);
    bus_bytes.push_back('{op, b});
    queued++;
  endfunction

  function automatic void queue_random_packet();
    logic [7:0] pkt[$];
    logic [7:0] id;
    logic [7:0] len;
    logic [7:0] err;
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] csum;
    int         n;
    int         noise;
    int         cut;
    n = (want_params > MAX_PARAMS) ? MAX_PARAMS : want_params;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 3)) queue_byte(1'($urandom_range(1)), 8'($urandom_range(255)));
      return;
    end
    if ($urandom_range(19) == 0) noise = hunt_limit + 2;
    else if ($urandom_range(3) == 0) noise = $urandom_range(1, 3);
    else noise = 0;
    repeat (noise) queue_byte(OP_BYTE, 8'($urandom_range(255)));
    if ($urandom_range(9) < 8 && want_id != ANY_ID && want_id != HDR_BYTE) id = want_id;
    else id = 8'($urandom_range(254));
    len = 8'(n) + LEN_EXTRA;
    if ($urandom_range(19) == 0) len = 8'($urandom_range(255));
    err = 8'($urandom_range(255));
    pkt.push_back(HDR_BYTE);
    pkt.push_back(HDR_BYTE);
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) pkt.push_back(HDR_BYTE);
    pkt.push_back(id);
    pkt.push_back(len);
    pkt.push_back(err);
    sum = id + len + err;
    repeat (n) begin
      b = 8'($urandom_range(255));
      pkt.push_back(b);
      sum = sum + b;
    end
    csum = ~sum;
    if ($urandom_range(14) == 0) csum = csum ^ 8'($urandom_range(1, 255));
    pkt.push_back(csum);
    cut = ($urandom_range(19) == 0) ? $urandom_range(0, pkt.size() - 1) : -1;
    foreach (pkt[i]) begin
      if (i == cut) begin
        queue_byte(OP_RESTART, 8'($urandom_range(255)));
        return;
      end
      queue_byte(OP_BYTE, pkt[i]);
    end
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_EXPECTED_ID:  want_id = val;
      CFG_PARAM_COUNT:  want_params = val[6:0];
      CFG_HEADER_LIMIT: hunt_limit = val;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (bus_bytes.size() != 0 || in_ch.valid || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(logic [7:0] id, logic [7:0] pcount, logic [7:0] limit,
                           int s_idle, int r_idle, bit squeeze);
    int start;
    wait_idle();
    write_reg(CFG_EXPECTED_ID, id);
    write_reg(CFG_PARAM_COUNT, pcount);
    write_reg(CFG_HEADER_LIMIT, limit);
    send_idle = s_idle;
    recv_idle = r_idle;
    if (squeeze) begin
      @(posedge clk);
      recv_hold_left <= HOLD_CYCLES;
    end
    start = queued;
    while (queued - start < PHASE_ITEMS) queue_random_packet();
  endtask

  initial begin
    rst            = 1'b1;
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_BYTE;
    in_ch.rx_byte  = 8'd0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = CFG_EXPECTED_ID;
    cfg_ch.data    = 8'd0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: any id, no params, hunt limit of one
    write_reg(CFG_EXPECTED_ID, ANY_ID);
    write_reg(CFG_PARAM_COUNT, 8'd0);
    write_reg(CFG_HEADER_LIMIT, 8'd1);
    send_idle = 15;
    recv_idle = 73;
    queue_byte(OP_BYTE, HDR_BYTE);
    queue_byte(OP_BYTE, HDR_BYTE);
    queue_byte(OP_BYTE, HDR_BYTE);
    queue_byte(OP_BYTE, 8'h00);
    queue_byte(OP_BYTE, 8'h02);
    queue_byte(OP_BYTE, 8'hEE);
    queue_byte(OP_BYTE, 8'h0F);
    queue_byte(OP_BYTE, 8'h00);
    queue_byte(OP_BYTE, 8'h00);
    queue_byte(OP_BYTE, HDR_BYTE);  // lone header byte counts as skipped
    queue_byte(OP_BYTE, 8'h00);
    queue_byte(OP_BYTE, HDR_BYTE);
    queue_byte(OP_BYTE, HDR_BYTE);
    queue_byte(OP_BYTE, 8'h00);
    queue_byte(OP_BYTE, 8'h03);     // length mismatch
    queue_byte(OP_BYTE, HDR_BYTE);
    queue_byte(OP_BYTE, HDR_BYTE);
    queue_byte(OP_RESTART, 8'hA5);
    queue_byte(OP_BYTE, HDR_BYTE);
    queue_byte(OP_BYTE, HDR_BYTE);
    queue_byte(OP_BYTE, ANY_ID);
    queue_byte(OP_BYTE, 8'h02);
    queue_byte(OP_BYTE, 8'h00);
    queue_byte(OP_BYTE, 8'h00);     // checksum off
    wait_idle();
    // id 0xFF can never match; oversized param count
    write_reg(CFG_EXPECTED_ID, 8'hFF);
    write_reg(CFG_PARAM_COUNT, 8'd127);
    write_reg(CFG_HEADER_LIMIT, 8'd255);
    queue_byte(OP_BYTE, HDR_BYTE);
    queue_byte(OP_BYTE, HDR_BYTE);
    queue_byte(OP_BYTE, 8'h05);

    run_phase(8'd1,   8'd0,   8'd10,  15, 73, 1'b0);
    run_phase(ANY_ID, 8'd3,   8'd255, 15, 73, 1'b0);
    run_phase(8'd7,   8'd100, 8'd5,   73, 15, 1'b0);
    run_phase(8'hFF,  8'd1,   8'd1,   73, 15, 1'b0);
    run_phase(8'd0,   8'd64,  8'd20,  0,  0,  1'b1);
    run_phase(ANY_ID, 8'd2,   8'd40,  0,  0,  1'b0);

    wait_idle();
    repeat (10) @(posedge clk);
    errors += expected_results.size();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
